// ===== hw/rtl/tmp_pkg.sv =====
// ----------------------------------------------------------------------------
// tmp_pkg
// Shared types, constants and saturating fixed-point helpers for the
// trapezoidal motion profile.
// ----------------------------------------------------------------------------
`default_nettype none

package tmp_pkg;

  localparam int FRAC_BITS_DEF = 16;

  typedef logic signed [63:0] q_t;

  localparam q_t          LIM     = 64'sh2000000000000000;
  localparam logic [61:0] LIM_MAG = 62'h2000000000000000;

  localparam logic [1:0] PH_ACCEL  = 2'd0;
  localparam logic [1:0] PH_CRUISE = 2'd1;
  localparam logic [1:0] PH_DECEL  = 2'd2;

  localparam logic [2:0] REG_START_POS = 3'd0;
  localparam logic [2:0] REG_START_VEL = 3'd1;
  localparam logic [2:0] REG_GOAL_POS  = 3'd2;
  localparam logic [2:0] REG_GOAL_VEL  = 3'd3;
  localparam logic [2:0] REG_MAX_ACCEL = 3'd4;
  localparam logic [2:0] REG_CRUISE    = 3'd5;

  typedef struct packed {
    logic        flip;
    q_t          a;
    q_t          iv;
    q_t          ip;
    q_t          t_acc;
    q_t          t_full;
    q_t          t_end;
    q_t          peak;
    q_t          base;
    q_t          base2;
    logic [31:0] tt;
  } plan_t;

  function automatic q_t clampl(input q_t x);
    if (x > LIM) begin
      return LIM;
    end
    if (x < -LIM) begin
      return -LIM;
    end
    return x;
  endfunction

  function automatic q_t sadd(input q_t x, input q_t y);
    q_t s;
    s = clampl(x) + clampl(y);
    return clampl(s);
  endfunction

  function automatic q_t ssub(input q_t x, input q_t y);
    q_t s;
    s = clampl(x) - clampl(y);
    return clampl(s);
  endfunction

  function automatic q_t half(input q_t x);
    q_t s;
    s = x + q_t'({63'd0, x[63]});
    return s >>> 1;
  endfunction

  function automatic logic [61:0] magn(input q_t x);
    q_t c;
    q_t m;
    c = clampl(x);
    m = c[63] ? -c : c;
    return m[61:0];
  endfunction

  function automatic logic [31:0] sat32s(input q_t x);
    logic [31:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'h7fffffff;
    end else if (x < -64'sd2147483648) begin
      r = 32'h80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/trapezoid_motion_profile.sv =====
// ----------------------------------------------------------------------------
// trapezoid_motion_profile
// Evaluates a trapezoidal or triangular velocity profile at each sample time.
//
//   Channel   Signals                          Direction  Content
//   sample    sample_valid/ready, sample_time  in         Q16.16 time
//   result    result_valid/ready, *_out, ...   out        profile values
//   cfg       cfg_valid/ready, cfg_index/data  in         register writes
//
// The evaluator accepts one sample per cycle unless a stall reaches the first
// stage or the plan is being rebuilt, and presents its result through six
// register stages with two multiplier passes. After reset and after every
// register write the plan is rebuilt by a sequencer with a bit-serial divider
// and square root; no sample is taken while it runs.
// Reset is synchronous. A stall holds each occupied stage while empty ones
// keep filling.
// ----------------------------------------------------------------------------
`default_nettype none

module trapezoid_motion_profile #(
  parameter int FRAC_BITS = tmp_pkg::FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        sample_valid,
  output logic             sample_ready,
  input  wire logic [31:0] sample_time,
  output logic             result_valid,
  input  wire logic        result_ready,
  output logic [31:0]      position_out,
  output logic [31:0]      velocity_out,
  output logic [31:0]      accel_out,
  output logic             in_range,
  output logic [1:0]       phase,
  output logic [31:0]      total_time,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  tmp_pkg::plan_t pl;
  logic           plan_done;

  logic v1, v2, v3, v4, v5;
  logic en1, en2, en3, en4, en5, en6;
  logic oor1, oor2, oor3, oor4, oor5;
  logic [1:0] ph1, ph2, ph3, ph4, ph5;
  tmp_pkg::q_t d1, k1;
  tmp_pkg::q_t mA, mB, mC, mD;
  tmp_pkg::q_t mb4, mc4, mb5, mc5;

  tmp_pkg::q_t tq, d_c, k_c;
  logic        oor_c;
  logic [1:0]  ph_c;
  tmp_pkg::q_t pp, vv, aa;

  assign cfg_ready = 1'b1;

  tmp_plan #(.FRAC_BITS(FRAC_BITS)) u_plan (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .done      (plan_done),
    .plan      (pl)
  );

  assign en6 = !result_valid || result_ready;
  assign en5 = !v5 || en6;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign sample_ready = en1 && plan_done;

  always_comb begin
    tq    = {32'd0, sample_time};
    oor_c = tq > pl.t_end;
    if (tq < pl.t_acc) begin
      ph_c = tmp_pkg::PH_ACCEL;
      d_c  = tq;
      k_c  = pl.iv;
    end else if (tq <= pl.t_full) begin
      ph_c = tmp_pkg::PH_CRUISE;
      d_c  = tmp_pkg::ssub(tq, pl.t_acc);
      k_c  = pl.peak;
    end else begin
      ph_c = tmp_pkg::PH_DECEL;
      d_c  = tmp_pkg::ssub(tq, pl.t_full);
      k_c  = pl.peak;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      v4           <= 1'b0;
      v5           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= sample_valid && plan_done;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en3) begin
        v3 <= v2;
      end
      if (en4) begin
        v4 <= v3;
      end
      if (en5) begin
        v5 <= v4;
      end
      if (en6) begin
        result_valid <= v5;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      oor1 <= oor_c;
      ph1  <= ph_c;
      d1   <= d_c;
      k1   <= k_c;
    end
    if (en2) begin
      oor2 <= oor1;
      ph2  <= ph1;
    end
    if (en3) begin
      oor3 <= oor2;
      ph3  <= ph2;
    end
    if (en4) begin
      oor4 <= oor3;
      ph4  <= ph3;
      mb4  <= mB;
      mc4  <= mC;
    end
    if (en5) begin
      oor5 <= oor4;
      ph5  <= ph4;
      mb5  <= mb4;
      mc5  <= mc4;
    end
  end

  tmp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_dd (
    .clk (clk), .en_p (en2), .en_r (en3), .a (d1), .b (d1), .p (mA)
  );

  tmp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_ad (
    .clk (clk), .en_p (en2), .en_r (en3), .a (pl.a), .b (d1), .p (mB)
  );

  tmp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_kd (
    .clk (clk), .en_p (en2), .en_r (en3), .a (k1), .b (d1), .p (mC)
  );

  tmp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_sq (
    .clk (clk), .en_p (en4), .en_r (en5), .a (pl.a), .b (mA), .p (mD)
  );

  always_comb begin
    case (ph5)
      tmp_pkg::PH_ACCEL: begin
        vv = tmp_pkg::sadd(pl.iv, mb5);
        pp = tmp_pkg::sadd(tmp_pkg::sadd(pl.ip, mc5), tmp_pkg::half(mD));
        aa = pl.a;
      end
      tmp_pkg::PH_CRUISE: begin
        vv = pl.peak;
        pp = tmp_pkg::sadd(pl.base, mc5);
        aa = '0;
      end
      default: begin
        vv = tmp_pkg::ssub(pl.peak, mb5);
        pp = tmp_pkg::ssub(tmp_pkg::sadd(pl.base2, mc5), tmp_pkg::half(mD));
        aa = -pl.a;
      end
    endcase
    if (pl.flip) begin
      vv = -vv;
      pp = -pp;
      aa = -aa;
    end
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      total_time <= pl.tt;
      if (oor5) begin
        position_out <= '0;
        velocity_out <= '0;
        accel_out    <= '0;
        in_range     <= 1'b0;
        phase        <= tmp_pkg::PH_ACCEL;
      end else begin
        position_out <= tmp_pkg::sat32s(pp);
        velocity_out <= tmp_pkg::sat32s(vv);
        accel_out    <= tmp_pkg::sat32s(aa);
        in_range     <= 1'b1;
        phase        <= ph5;
      end
    end
  end

  a_ready_needs_plan: assert property (@(posedge clk) disable iff (rst)
    sample_ready |-> plan_done)
    else $error("Sample taken while the plan is being rebuilt.");

  a_out_of_range_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !in_range |-> position_out == 32'd0 && velocity_out == 32'd0
      && accel_out == 32'd0 && phase == tmp_pkg::PH_ACCEL)
    else $error("Out-of-range result carries nonzero values.");

  a_cruise_no_accel: assert property (@(posedge clk) disable iff (rst)
    result_valid && in_range && phase == tmp_pkg::PH_CRUISE |-> accel_out == 32'd0)
    else $error("Cruise phase reports nonzero acceleration.");

  a_fill_after_accept: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready |=> v1)
    else $error("Accepted sample did not enter the first stage.");

endmodule

`default_nettype wire

// ===== hw/rtl/tmp_mul.sv =====
// ----------------------------------------------------------------------------
// tmp_mul
// Two-stage saturating fixed-point multiplier built from four 31x31
// partial products.
// ----------------------------------------------------------------------------
`default_nettype none

module tmp_mul #(
  parameter int FRAC_BITS = tmp_pkg::FRAC_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          en_p,
  input  wire logic          en_r,
  input  wire tmp_pkg::q_t   a,
  input  wire tmp_pkg::q_t   b,
  output tmp_pkg::q_t        p
);

  logic [61:0]  ma_c;
  logic [61:0]  mb_c;
  logic [61:0]  ll;
  logic [61:0]  lh;
  logic [61:0]  hl;
  logic [61:0]  hh;
  logic         neg;
  logic [62:0]  mid;
  logic [123:0] full;
  logic [123:0] sh;
  logic [61:0]  mag;
  tmp_pkg::q_t  r;

  assign ma_c = tmp_pkg::magn(a);
  assign mb_c = tmp_pkg::magn(b);

  always_ff @(posedge clk) begin
    if (en_p) begin
      ll  <= ma_c[30:0] * mb_c[30:0];
      lh  <= ma_c[30:0] * mb_c[61:31];
      hl  <= ma_c[61:31] * mb_c[30:0];
      hh  <= ma_c[61:31] * mb_c[61:31];
      neg <= a[63] ^ b[63];
    end
  end

  always_comb begin
    mid  = {1'b0, lh} + {1'b0, hl};
    full = ({62'd0, hh} << 62) + ({61'd0, mid} << 31) + {62'd0, ll};
    sh   = full >> FRAC_BITS;
    if ((|sh[123:62]) || (sh[61:0] > tmp_pkg::LIM_MAG)) begin
      mag = tmp_pkg::LIM_MAG;
    end else begin
      mag = sh[61:0];
    end
    r = {2'b00, mag};
  end

  always_ff @(posedge clk) begin
    if (en_r) begin
      p <= neg ? -r : r;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tmp_plan.sv =====
// ----------------------------------------------------------------------------
// tmp_plan
// Configuration registers and the sequencer that plans the profile with a
// shared multiplier, a bit-serial divider and a bit-serial square root.
// ----------------------------------------------------------------------------
`default_nettype none

module tmp_plan #(
  parameter int FRAC_BITS = tmp_pkg::FRAC_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_valid,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [31:0]   cfg_data,
  output logic               done,
  output tmp_pkg::plan_t     plan
);

  localparam int DW = 62 + FRAC_BITS;
  localparam int SW = ((63 + FRAC_BITS) / 2) * 2;
  localparam int RH = SW / 2;
  localparam int CW = $clog2(DW + 1);

  typedef enum logic [4:0] {
    ST_IDLE, ST_INIT, ST_MWAIT, ST_DIV, ST_SQRT, ST_TDEC, ST_TACC, ST_M1, ST_M2,
    ST_FULL, ST_SQ1, ST_SQ2, ST_SQ3, ST_SQ4, ST_SQ5, ST_SQ6, ST_PK2, ST_PK3,
    ST_PK4
  } state_t;

  state_t state;
  state_t ret;
  state_t ret_c;

  logic [31:0] sp;
  logic [31:0] sv;
  logic [31:0] gp;
  logic [31:0] gvr;
  logic [30:0] acc;
  logic [30:0] cvr;

  tmp_pkg::q_t iv, gv, ip, err, a, cv, t_acc, t_dec, t_full, t_end, tmp, pk;
  tmp_pkg::q_t peak, base, base2;
  logic        flip;
  logic [31:0] tt;

  tmp_pkg::q_t i_sp, i_gp, i_sv, i_gv, i_iv, i_a, i_cv;
  logic        i_flip;

  tmp_pkg::q_t ma, mb, mr;
  logic        mcnt;
  logic        go_mul, go_div, go_sqrt;
  tmp_pkg::q_t op_a, op_b, dn, rad, s_pos;
  logic [30:0] dd;

  logic [DW-1:0] dv_num;
  logic [DW-1:0] dv_quo;
  logic [31:0]   dv_rem;
  logic [30:0]   dv_den;
  logic          dv_neg;
  logic [CW-1:0] cnt;
  logic [31:0]   rem_sh;
  logic          ge;
  tmp_pkg::q_t   q_mag, dq;

  logic [SW-1:0] sq_num;
  logic [RH+1:0] sq_rem;
  logic [RH-1:0] sq_root;
  logic [RH+1:0] sq_sh;
  logic [RH+1:0] sq_trial;
  tmp_pkg::q_t   root_q;

  tmp_pkg::q_t area_c, full_c, peak_c, base_c, tend_c;

  tmp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk  (clk),
    .en_p (1'b1),
    .en_r (1'b1),
    .a    (ma),
    .b    (mb),
    .p    (mr)
  );

  always_comb begin
    i_sp   = {{32{sp[31]}}, sp};
    i_gp   = {{32{gp[31]}}, gp};
    i_flip = i_sp > i_gp;
    i_sv   = i_flip ? -{{32{sv[31]}}, sv} : {{32{sv[31]}}, sv};
    i_gv   = i_flip ? -{{32{gvr[31]}}, gvr} : {{32{gvr[31]}}, gvr};
    i_a    = (acc == 31'd0) ? 64'sd1 : {33'd0, acc};
    i_cv   = (cvr == 31'd0) ? 64'sd1 : {33'd0, cvr};
    i_iv   = (i_sv > i_cv) ? i_cv : i_sv;
  end

  always_comb begin
    rem_sh = {dv_rem[30:0], dv_num[DW-1]};
    ge     = rem_sh >= {1'b0, dv_den};
    if ((|dv_quo[DW-1:62]) || (dv_quo[61:0] > tmp_pkg::LIM_MAG)) begin
      q_mag = tmp_pkg::LIM;
    end else begin
      q_mag = {2'b00, dv_quo[61:0]};
    end
    dq       = dv_neg ? -q_mag : q_mag;
    sq_sh    = {sq_rem[RH-1:0], sq_num[SW-1:SW-2]};
    sq_trial = {sq_root, 2'b01};
    root_q   = tmp_pkg::q_t'(sq_root);
  end

  always_comb begin
    go_mul  = 1'b0;
    go_div  = 1'b0;
    go_sqrt = 1'b0;
    op_a    = '0;
    op_b    = '0;
    dn      = '0;
    dd      = a[30:0];
    rad     = '0;
    ret_c   = ST_IDLE;
    area_c  = tmp_pkg::ssub(tmp_pkg::ssub(err, tmp), tmp_pkg::half(mr));
    full_c  = tmp_pkg::sadd(t_acc, dq);
    peak_c  = tmp_pkg::sadd(iv, mr);
    base_c  = tmp_pkg::sadd(ip, tmp_pkg::half(mr));
    tend_c  = tmp_pkg::sadd(dq, t_full);
    case (state)
      ST_INIT: begin
        go_div = 1'b1;
        dn     = i_cv - i_gv;
        dd     = i_a[30:0];
        ret_c  = ST_TDEC;
      end
      ST_TDEC: begin
        if (iv == cv) begin
          go_mul = 1'b1;
          op_a   = dq;
          op_b   = cv + gv;
          ret_c  = ST_M1;
        end else begin
          go_div = 1'b1;
          dn     = cv - iv;
          ret_c  = ST_TACC;
        end
      end
      ST_TACC: begin
        go_mul = 1'b1;
        op_a   = t_dec;
        op_b   = cv + gv;
        ret_c  = ST_M1;
      end
      ST_M1: begin
        go_mul = 1'b1;
        op_a   = t_acc;
        op_b   = cv + iv;
        ret_c  = ST_M2;
      end
      ST_M2: begin
        if (area_c <= 64'sd0) begin
          go_mul = 1'b1;
          op_a   = iv;
          op_b   = iv;
          ret_c  = ST_SQ1;
        end else begin
          go_div = 1'b1;
          dn     = area_c;
          dd     = cv[30:0];
          ret_c  = ST_FULL;
        end
      end
      ST_FULL: begin
        go_mul = 1'b1;
        op_a   = a;
        op_b   = t_acc;
        ret_c  = ST_PK2;
      end
      ST_SQ1: begin
        go_mul = 1'b1;
        op_a   = gv;
        op_b   = gv;
        ret_c  = ST_SQ2;
      end
      ST_SQ2: begin
        go_mul = 1'b1;
        op_a   = a;
        op_b   = err;
        ret_c  = ST_SQ3;
      end
      ST_SQ3: begin
        go_sqrt = 1'b1;
        rad     = tmp_pkg::sadd(mr, tmp);
        ret_c   = ST_SQ4;
      end
      ST_SQ4: begin
        go_div = 1'b1;
        dn     = root_q - iv;
        ret_c  = ST_SQ5;
      end
      ST_SQ5: begin
        go_div = 1'b1;
        dn     = pk - gv;
        ret_c  = ST_SQ6;
      end
      ST_SQ6: begin
        go_mul = 1'b1;
        op_a   = a;
        op_b   = t_acc;
        ret_c  = ST_PK2;
      end
      ST_PK2: begin
        go_mul = 1'b1;
        op_a   = iv + peak_c;
        op_b   = t_acc;
        ret_c  = ST_PK3;
      end
      ST_PK3: begin
        go_mul = 1'b1;
        op_a   = peak;
        op_b   = tmp_pkg::ssub(t_full, t_acc);
        ret_c  = ST_PK4;
      end
      default: begin
        go_mul = 1'b0;
      end
    endcase
    s_pos = rad[63] ? 64'sd0 : rad;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      ret   <= ST_IDLE;
      sp    <= '0;
      sv    <= '0;
      gp    <= '0;
      gvr   <= '0;
      acc   <= 31'(1) << FRAC_BITS;
      cvr   <= 31'(1) << FRAC_BITS;
    end else if (cfg_valid) begin
      case (cfg_index)
        tmp_pkg::REG_START_POS: sp  <= cfg_data;
        tmp_pkg::REG_START_VEL: sv  <= cfg_data;
        tmp_pkg::REG_GOAL_POS:  gp  <= cfg_data;
        tmp_pkg::REG_GOAL_VEL:  gvr <= cfg_data;
        tmp_pkg::REG_MAX_ACCEL: acc <= cfg_data[30:0];
        tmp_pkg::REG_CRUISE:    cvr <= cfg_data[30:0];
        default: begin
        end
      endcase
      state <= ST_INIT;
    end else begin
      if (go_mul) begin
        ma    <= op_a;
        mb    <= op_b;
        mcnt  <= 1'b0;
        ret   <= ret_c;
        state <= ST_MWAIT;
      end
      if (go_div) begin
        dv_num <= DW'(tmp_pkg::magn(dn)) << FRAC_BITS;
        dv_quo <= '0;
        dv_rem <= '0;
        dv_den <= dd;
        dv_neg <= dn[63];
        cnt    <= CW'(DW);
        ret    <= ret_c;
        state  <= ST_DIV;
      end
      if (go_sqrt) begin
        sq_num  <= SW'(s_pos[61:0]) << FRAC_BITS;
        sq_rem  <= '0;
        sq_root <= '0;
        cnt     <= CW'(RH);
        ret     <= ret_c;
        state   <= ST_SQRT;
      end
      case (state)
        ST_INIT: begin
          flip <= i_flip;
          ip   <= i_flip ? -i_sp : i_sp;
          err  <= i_flip ? i_sp - i_gp : i_gp - i_sp;
          iv   <= i_iv;
          gv   <= i_gv;
          a    <= i_a;
          cv   <= i_cv;
        end
        ST_TDEC: begin
          t_dec <= dq;
          if (iv == cv) begin
            t_acc <= '0;
          end
        end
        ST_TACC: t_acc <= dq;
        ST_M1:   tmp   <= tmp_pkg::half(mr);
        ST_FULL: begin
          t_full <= full_c;
          t_end  <= tmp_pkg::sadd(t_dec, full_c);
        end
        ST_SQ1: tmp <= mr;
        ST_SQ2: tmp <= tmp_pkg::half(tmp_pkg::sadd(tmp, mr));
        ST_SQ4: pk  <= root_q;
        ST_SQ5: begin
          t_acc  <= dq;
          t_full <= dq;
        end
        ST_SQ6: begin
          t_dec <= dq;
          t_end <= tend_c;
        end
        ST_PK2: peak <= peak_c;
        ST_PK3: base <= base_c;
        ST_PK4: begin
          base2 <= tmp_pkg::sadd(base, mr);
          if (t_end < 64'sd0) begin
            tt <= '0;
          end else if (t_end > 64'sd4294967295) begin
            tt <= '1;
          end else begin
            tt <= t_end[31:0];
          end
          state <= ST_IDLE;
        end
        ST_MWAIT: begin
          if (mcnt) begin
            state <= ret;
          end else begin
            mcnt <= 1'b1;
          end
        end
        ST_DIV: begin
          dv_rem <= ge ? rem_sh - {1'b0, dv_den} : rem_sh;
          dv_num <= dv_num << 1;
          dv_quo <= {dv_quo[DW-2:0], ge};
          cnt    <= cnt - CW'(1);
          if (cnt == CW'(1)) begin
            state <= ret;
          end
        end
        ST_SQRT: begin
          if (sq_sh >= sq_trial) begin
            sq_rem  <= sq_sh - sq_trial;
            sq_root <= {sq_root[RH-2:0], 1'b1};
          end else begin
            sq_rem  <= sq_sh;
            sq_root <= {sq_root[RH-2:0], 1'b0};
          end
          sq_num <= sq_num << 2;
          cnt    <= cnt - CW'(1);
          if (cnt == CW'(1)) begin
            state <= ret;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign done = (state == ST_IDLE);

  always_comb begin
    plan.flip   = flip;
    plan.a      = a;
    plan.iv     = iv;
    plan.ip     = ip;
    plan.t_acc  = t_acc;
    plan.t_full = t_full;
    plan.t_end  = t_end;
    plan.peak   = peak;
    plan.base   = base;
    plan.base2  = base2;
    plan.tt     = tt;
  end

endmodule

`default_nettype wire
